// ===== hdl/box_filter_5x5_stream_top_defines.svh =====
// Assertion macros shared by the box filter modules.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef BOX_FILTER_5X5_STREAM_TOP_DEFINES_SVH
`define BOX_FILTER_5X5_STREAM_TOP_DEFINES_SVH

`define BFX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define BFX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bfx_pkg.sv =====
`timescale 1ns / 1ps

package bfx_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int WIN         = 5;
  localparam int BUF_ROWS    = WIN - 1;
  localparam int WIN_COUNT   = WIN * WIN;

  localparam int PIX_W       = 16;
  localparam int WIDTH_REG_W = 11;
  localparam int HEIGHT_W    = 16;
  localparam int OFFSET_W    = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;

  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int EW_W        = $clog2(MAX_WIDTH + 1);
  localparam int WCMP_W      = (EW_W > WIDTH_REG_W) ? EW_W : WIDTH_REG_W;
  localparam int LINE_W      = BUF_ROWS * PIX_W;

  localparam int ROWSUM_W    = PIX_W + $clog2(WIN);
  localparam int SUM_W       = PIX_W + $clog2(WIN_COUNT);

  localparam int RECIP_SHIFT = SUM_W + 5;
  localparam longint unsigned RECIP_MULT_L =
    ((64'd1 << RECIP_SHIFT) + WIN_COUNT - 1) / WIN_COUNT;
  localparam int RECIP_W     = $clog2(RECIP_MULT_L + 1);
  localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'(RECIP_MULT_L);
  localparam int PROD_W      = SUM_W + RECIP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_RESULT_OFFSET = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic emit;
    logic last;
  } tag_t;

endpackage

// ===== hdl/box_filter_5x5_stream_top.sv =====
`timescale 1ns / 1ps
`include "box_filter_5x5_stream_top_defines.svh"

// 5x5 box filter over a raster-order stream of 16-bit unsigned pixels.
// Pixels enter on the in_valid_i / in_ready_o channel, one beat per pixel.
// Each interior pixel position gives one beat on out_valid_o / out_ready_i
// carrying the truncated window mean plus result_offset, modulo 2^16, and
// frame_last_o marks the last result of the frame. Border pixels give no beat.
// Throughput is one pixel per cycle: the column line memory is read once and
// written once per pixel, and the adder tree and reciprocal multiply are
// pipelined into row sum, total, quotient and output register stages.
// When the receiver stalls, the stages fill up behind the output register and
// in_ready_o drops once the stage holding the line memory read is blocked.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i; the
// user must do so only while the block is idle; the block does not enforce it.
// Reset sets the registers to width 1024, height 1024 and offset 2, clears
// the position counters and the window, and empties the pipeline. The line
// memory is not cleared; it needs no clearing pass, as no result reads an unwritten entry.
module box_filter_5x5_stream_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bfx_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfx_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bfx_pkg::PIX_W-1:0]      pixel_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bfx_pkg::PIX_W-1:0]      filtered_value_o,
  output logic                           frame_last_o
);
  import bfx_pkg::*;

  logic [WIDTH_REG_W-1:0] img_w_q;
  logic [HEIGHT_W-1:0]    img_h_q;
  logic [OFFSET_W-1:0]    offset_q;

  logic [COL_W-1:0]       col_q, col_d;
  logic [HEIGHT_W-1:0]    row_q, row_d;

  logic [WCMP_W-1:0]      w_ext;
  logic [EW_W-1:0]        eff_w;
  logic [HEIGHT_W-1:0]    eff_h;
  logic [COL_W-1:0]       w_last;
  logic [HEIGHT_W-1:0]    h_last;
  logic [COL_W-1:0]       c_eff;
  logic [HEIGHT_W-1:0]    r_eff;
  tag_t                   tag_d;

  logic                   v1_q, v2_q;
  logic [PIX_W-1:0]       px1_q;
  logic [COL_W-1:0]       col1_q;
  tag_t                   tag1_q, tag2_q;

  logic                   in_acc;
  logic                   ready2;
  logic                   s1_adv;
  logic                   mean_in_ready;
  logic [LINE_W-1:0]      rd_word;
  logic [LINE_W-1:0]      wr_word;
  logic [PIX_W-1:0]       win [WIN][WIN];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q  <= WIDTH_REG_W'(1024);
      img_h_q  <= HEIGHT_W'(1024);
      offset_q <= OFFSET_W'(2);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:   img_w_q  <= cfg_data_i[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT:  img_h_q  <= cfg_data_i[HEIGHT_W-1:0];
        REG_RESULT_OFFSET: offset_q <= cfg_data_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size and the clamped position of the incoming pixel.
  always_comb begin
    w_ext = WCMP_W'(img_w_q);
    if (w_ext < WCMP_W'(WIN)) begin
      eff_w = EW_W'(WIN);
    end else if (w_ext > WCMP_W'(MAX_WIDTH)) begin
      eff_w = EW_W'(MAX_WIDTH);
    end else begin
      eff_w = EW_W'(w_ext);
    end
    eff_h  = (img_h_q < HEIGHT_W'(WIN)) ? HEIGHT_W'(WIN) : img_h_q;
    w_last = COL_W'(eff_w - 1'b1);
    h_last = eff_h - 1'b1;
    c_eff  = (col_q > w_last) ? w_last : col_q;
    r_eff  = (row_q > h_last) ? h_last : row_q;

    tag_d.emit = (r_eff >= HEIGHT_W'(BUF_ROWS)) && (c_eff >= COL_W'(BUF_ROWS));
    tag_d.last = (r_eff == h_last) && (c_eff == w_last);

    if (c_eff >= w_last) begin
      col_d = '0;
      row_d = (r_eff >= h_last) ? '0 : r_eff + 1'b1;
    end else begin
      col_d = c_eff + 1'b1;
      row_d = r_eff;
    end
  end

  assign ready2     = !v2_q || !tag2_q.emit || mean_in_ready;
  assign s1_adv     = v1_q && ready2;
  assign in_ready_o = !v1_q || ready2;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_ready_o) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px1_q  <= pixel_value_i;
      col1_q <= c_eff;
      tag1_q <= tag_d;
    end
    if (ready2) begin
      tag2_q <= tag1_q;
    end
  end

  bfx_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (c_eff),
    .rd_data_o (rd_word),
    .wr_en_i   (s1_adv),
    .wr_addr_i (col1_q),
    .wr_data_i (wr_word)
  );

  bfx_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .shift_i   (s1_adv),
    .rd_word_i (rd_word),
    .pixel_i   (px1_q),
    .wr_word_o (wr_word),
    .win_o     (win)
  );

  bfx_mean u_mean (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (v2_q),
    .in_ready_o       (mean_in_ready),
    .in_tag_i         (tag2_q),
    .win_i            (win),
    .offset_i         (offset_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .filtered_value_o (filtered_value_o),
    .frame_last_o     (frame_last_o)
  );

  `BFX_ASSERT_NXT(a_read_held, v1_q && !ready2, $stable(rd_word),
                  "line buffer read data changed under a stalled pixel")
  `BFX_ASSERT_NXT(a_col_step, in_acc, (col_q == '0) || (col_q == COL_W'($past(c_eff) + 1'b1)),
                  "column counter did not step or wrap")

endmodule

// ===== hdl/bfx_line_buf.sv =====
`timescale 1ns / 1ps
`include "box_filter_5x5_stream_top_defines.svh"

module bfx_line_buf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [bfx_pkg::COL_W-1:0]  rd_addr_i,
  output logic [bfx_pkg::LINE_W-1:0] rd_data_o,
  input  logic                       wr_en_i,
  input  logic [bfx_pkg::COL_W-1:0]  wr_addr_i,
  input  logic [bfx_pkg::LINE_W-1:0] wr_data_i
);
  import bfx_pkg::*;

  logic [LINE_W-1:0] line_mem_q [MAX_WIDTH];
  logic [LINE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      line_mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= line_mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

  `BFX_ASSERT_IMP(a_no_rw_collision, rd_en_i && wr_en_i, rd_addr_i != wr_addr_i,
                  "line buffer read and write hit the same column")

endmodule

// ===== hdl/bfx_window.sv =====
`timescale 1ns / 1ps

module bfx_window (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       shift_i,
  input  logic [bfx_pkg::LINE_W-1:0] rd_word_i,
  input  logic [bfx_pkg::PIX_W-1:0]  pixel_i,
  output logic [bfx_pkg::LINE_W-1:0] wr_word_o,
  output logic [bfx_pkg::PIX_W-1:0]  win_o [bfx_pkg::WIN][bfx_pkg::WIN]
);
  import bfx_pkg::*;

  logic [PIX_W-1:0] win_q [WIN][WIN];
  logic [PIX_W-1:0] col_new [WIN];

  // New window column, oldest row first, with the incoming pixel at the bottom.
  always_comb begin
    for (int i = 0; i < BUF_ROWS; i++) begin
      col_new[i] = rd_word_i[PIX_W*(BUF_ROWS-1-i) +: PIX_W];
    end
    col_new[BUF_ROWS] = pixel_i;
  end

  // Each row ages by one slot and the pixel becomes the newest row.
  assign wr_word_o = {rd_word_i[LINE_W-PIX_W-1:0], pixel_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (shift_i) begin
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN - 1; j++) begin
          win_q[i][j] <= win_q[i][j+1];
        end
        win_q[i][WIN-1] <= col_new[i];
      end
    end
  end

  assign win_o = win_q;

endmodule

// ===== hdl/bfx_mean.sv =====
`timescale 1ns / 1ps

module bfx_mean (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bfx_pkg::tag_t                in_tag_i,
  input  logic [bfx_pkg::PIX_W-1:0]    win_i [bfx_pkg::WIN][bfx_pkg::WIN],
  input  logic [bfx_pkg::OFFSET_W-1:0] offset_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bfx_pkg::PIX_W-1:0]    filtered_value_o,
  output logic                         frame_last_o
);
  import bfx_pkg::*;

  logic                v3_q, v4_q, v5_q, v6_q;
  logic                last3_q, last4_q, last5_q, last6_q;
  logic [ROWSUM_W-1:0] rowsum_d [WIN];
  logic [ROWSUM_W-1:0] rowsum_q [WIN];
  logic [SUM_W-1:0]    total_d, total_q;
  logic [PROD_W-1:0]   prod;
  logic [PIX_W-1:0]    quot_q;
  logic [PIX_W-1:0]    out_q;
  logic                ready4, ready5, ready6;

  assign ready6     = !v6_q || out_ready_i;
  assign ready5     = !v5_q || ready6;
  assign ready4     = !v4_q || ready5;
  assign in_ready_o = !v3_q || ready4;

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      rowsum_d[i] = '0;
      for (int j = 0; j < WIN; j++) begin
        rowsum_d[i] = rowsum_d[i] + ROWSUM_W'(win_i[i][j]);
      end
    end
  end

  always_comb begin
    total_d = '0;
    for (int i = 0; i < WIN; i++) begin
      total_d = total_d + SUM_W'(rowsum_q[i]);
    end
  end

  // Division by the window area through a scaled reciprocal; exact over the sum range.
  assign prod = PROD_W'(total_q) * PROD_W'(RECIP_MULT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v3_q <= in_valid_i && in_tag_i.emit;
      end
      if (ready4) begin
        v4_q <= v3_q;
      end
      if (ready5) begin
        v5_q <= v4_q;
      end
      if (ready6) begin
        v6_q <= v5_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      rowsum_q <= rowsum_d;
      last3_q  <= in_tag_i.last;
    end
    if (ready4) begin
      total_q <= total_d;
      last4_q <= last3_q;
    end
    if (ready5) begin
      quot_q  <= prod[RECIP_SHIFT +: PIX_W];
      last5_q <= last4_q;
    end
    if (ready6) begin
      out_q   <= quot_q + offset_i;
      last6_q <= last5_q;
    end
  end

  assign out_valid_o      = v6_q;
  assign filtered_value_o = out_q;
  assign frame_last_o     = last6_q;

endmodule
